/* hw/rtl/csvt_pkg.sv */
// csvt_pkg: shared types and constants of the CSV field tokenizer.
// Holds the beat payload structs, parse mode encoding, status codes and
// byte constants; depends on nothing.
package csvt_pkg;

   localparam int unsigned CSR_ADDR_BITS = 3;
   localparam int unsigned CSR_DATA_BITS = 32;

   // register byte addresses
   localparam logic [CSR_ADDR_BITS-1:0] REG_SEPARATOR = 3'd0;

   localparam logic [7:0] SEPARATOR_RESET = 8'd44;

   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_QUOTE_BARE = 3'd1;
   localparam logic [2:0] STATUS_AFTER_QUOT = 3'd2;
   localparam logic [2:0] STATUS_UNCLOSED   = 3'd3;
   localparam logic [2:0] STATUS_MISMATCH   = 3'd4;

   typedef enum logic [5:0] {
      MODE_START    = 6'b000001,
      MODE_PLAIN    = 6'b000010,
      MODE_QUOTED   = 6'b000100,
      MODE_QSEEN    = 6'b001000,
      MODE_AFTER_CR = 6'b010000,
      MODE_DONE     = 6'b100000
   } parse_mode_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_data;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        field_end;
      logic        row_end;
      logic        finished;
      logic [2:0]  status;
      logic [15:0] row_index;
      logic [7:0]  column_index;
      logic [7:0]  expected_columns;
   } rsp_payload_type;

endpackage

/* hw/rtl/csv_field_tokenizer_core.sv */
// csv_field_tokenizer_core: streaming CSV tokenizer, top level.
// Instantiates csvt_parser and csvt_rsp_fifo; uses csvt_pkg.
//
// Usage:
//  - req channel: one CSV byte per beat (data_byte, end_of_data). A beat
//    is taken when req_valid is high and req_stall is low. A zero byte or
//    end_of_data closes the parse and re-arms the block for the next one.
//  - rsp channel: zero or one result beat per input byte: a field byte,
//    a field/row end mark, or the final beat (finished=1) with status.
//  - CSR port (APB style): register 0 at byte address 0 is the separator,
//    reset value ','. Write it only while the block is idle.
//  - Timing: a byte is registered on entry and parsed in the next cycle;
//    its result is pushed into the output FIFO, which drives rsp. One byte
//    per cycle sustained while req_stall stays low: the parse step is a
//    single state update on the byte register.
//  - Stalling: the 3-entry result FIFO absorbs the byte in flight; req_stall
//    rises when the input register plus the FIFO fill reach 3, so no result
//    is ever dropped and req_stall does not depend on rsp_stall directly.
//  - Reset (synchronous, active high) clears parse state, FIFO and
//    separator; the block takes bytes from the first cycle after reset.
module csv_field_tokenizer_core
   import csvt_pkg::*;
#(
   parameter int unsigned ROW_BITS = 16,
   parameter int unsigned COL_BITS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   // byte input
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_payload_type            req_data,
   // result output
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_payload_type            rsp_data,
   // config port
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [CSR_ADDR_BITS-1:0]   paddr,
   input  logic [CSR_DATA_BITS-1:0]   pwdata,
   output logic [CSR_DATA_BITS-1:0]   prdata,
   output logic                       pready
);

   localparam int unsigned FIFO_DEPTH = 3;
   localparam int unsigned LVL_BITS   = $clog2(FIFO_DEPTH+1);

   // config register
   logic [7:0] separator_ff, separator_in;

   // input register stage
   logic            in_valid_ff, in_valid_in;
   req_payload_type in_ff;
   logic            req_take;

   // parse state
   parse_mode_type      mode_ff, mode_in;
   logic                any_seen_ff, any_seen_in;
   logic [ROW_BITS-1:0] row_cnt_ff, row_cnt_in;
   logic [COL_BITS-1:0] field_cnt_ff, field_cnt_in;
   logic [COL_BITS-1:0] first_fields_ff, first_fields_in;
   logic                mm_seen_ff, mm_seen_in;
   logic [ROW_BITS-1:0] mm_row_ff, mm_row_in;
   logic [COL_BITS-1:0] mm_fields_ff, mm_fields_in;

   logic            has_result;
   rsp_payload_type result;
   logic [LVL_BITS-1:0] fifo_level;
   logic [LVL_BITS:0]   occupancy;

   // ---------------- config port ----------------
   assign pready = 1'b1;

   always_comb begin
      separator_in = separator_ff;
      if (psel && penable && pwrite && (paddr == REG_SEPARATOR)) begin
         separator_in = pwdata[7:0];
      end
   end

   assign prdata = (paddr == REG_SEPARATOR) ? {{(CSR_DATA_BITS-8){1'b0}}, separator_ff} : '0;

   // ---------------- input stage ----------------
   // bytes in flight: the input register plus everything queued for output
   assign occupancy   = {{LVL_BITS{1'b0}}, in_valid_ff} + {1'b0, fifo_level};
   assign req_stall   = (occupancy >= (LVL_BITS+1)'(FIFO_DEPTH));
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take;

   // ---------------- parse step ----------------
   csvt_parser #(
      .ROW_BITS (ROW_BITS),
      .COL_BITS (COL_BITS)
   ) u_parser (
      .item            (in_ff),
      .separator       (separator_ff),
      .mode            (mode_ff),
      .any_seen        (any_seen_ff),
      .row_cnt         (row_cnt_ff),
      .field_cnt       (field_cnt_ff),
      .first_fields    (first_fields_ff),
      .mm_seen         (mm_seen_ff),
      .mm_row          (mm_row_ff),
      .mm_fields       (mm_fields_ff),
      .mode_in         (mode_in),
      .any_seen_in     (any_seen_in),
      .row_cnt_in      (row_cnt_in),
      .field_cnt_in    (field_cnt_in),
      .first_fields_in (first_fields_in),
      .mm_seen_in      (mm_seen_in),
      .mm_row_in       (mm_row_in),
      .mm_fields_in    (mm_fields_in),
      .has_result      (has_result),
      .result          (result)
   );

   // ---------------- result queue ----------------
   csvt_rsp_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (in_valid_ff && has_result),
      .push_data (result),
      .pop       (!rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .level     (fifo_level)
   );

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         separator_ff    <= SEPARATOR_RESET;
         in_valid_ff     <= 1'b0;
         mode_ff         <= MODE_START;
         any_seen_ff     <= 1'b0;
         row_cnt_ff      <= '0;
         field_cnt_ff    <= '0;
         first_fields_ff <= '0;
         mm_seen_ff      <= 1'b0;
         mm_row_ff       <= '0;
         mm_fields_ff    <= '0;
      end else begin
         separator_ff <= separator_in;
         in_valid_ff  <= in_valid_in;
         // state advances only on a parsed byte
         if (in_valid_ff) begin
            mode_ff         <= mode_in;
            any_seen_ff     <= any_seen_in;
            row_cnt_ff      <= row_cnt_in;
            field_cnt_ff    <= field_cnt_in;
            first_fields_ff <= first_fields_in;
            mm_seen_ff      <= mm_seen_in;
            mm_row_ff       <= mm_row_in;
            mm_fields_ff    <= mm_fields_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= req_data;
      end
   end

endmodule

/* hw/rtl/csvt_parser.sv */
// csvt_parser: one-byte parse step, pure combinational logic.
// Computes next parse state and the optional result beat; uses csvt_pkg.
module csvt_parser
   import csvt_pkg::*;
#(
   parameter int unsigned ROW_BITS = 16,
   parameter int unsigned COL_BITS = 8
) (
   input  req_payload_type      item,
   input  logic [7:0]           separator,
   input  parse_mode_type       mode,
   input  logic                 any_seen,
   input  logic [ROW_BITS-1:0]  row_cnt,
   input  logic [COL_BITS-1:0]  field_cnt,
   input  logic [COL_BITS-1:0]  first_fields,
   input  logic                 mm_seen,
   input  logic [ROW_BITS-1:0]  mm_row,
   input  logic [COL_BITS-1:0]  mm_fields,
   output parse_mode_type       mode_in,
   output logic                 any_seen_in,
   output logic [ROW_BITS-1:0]  row_cnt_in,
   output logic [COL_BITS-1:0]  field_cnt_in,
   output logic [COL_BITS-1:0]  first_fields_in,
   output logic                 mm_seen_in,
   output logic [ROW_BITS-1:0]  mm_row_in,
   output logic [COL_BITS-1:0]  mm_fields_in,
   output logic                 has_result,
   output rsp_payload_type      result
);

   typedef struct packed {
      logic [COL_BITS-1:0] first;
      logic                seen;
      logic [ROW_BITS-1:0] row;
      logic [COL_BITS-1:0] fields;
   } rowchk_type;

   function automatic rowchk_type close_row(rowchk_type cur, logic [ROW_BITS-1:0] row,
                                            logic [COL_BITS-1:0] cnt);
      rowchk_type nxt;
      nxt = cur;
      if (row == '0) begin
         nxt.first = cnt;
      end else if (cnt != cur.first && !cur.seen) begin
         nxt.seen   = 1'b1;
         nxt.row    = row;
         nxt.fields = cnt;
      end
      return nxt;
   endfunction

   function automatic logic [15:0] row_out(logic [ROW_BITS-1:0] row);
      logic [ROW_BITS+15:0] wide;
      wide = {16'b0, row};
      return wide[15:0];
   endfunction

   function automatic logic [7:0] col_out(logic [COL_BITS-1:0] col);
      logic [COL_BITS+7:0] wide;
      wide = {8'b0, col};
      return wide[7:0];
   endfunction

   function automatic logic [COL_BITS-1:0] col_inc(logic [COL_BITS-1:0] col);
      return (col != '1) ? col + 1'b1 : col;
   endfunction

   always_comb begin
      logic            is_end;
      logic            is_q;
      logic            is_s;
      logic            is_nl;
      logic            skip;
      logic            do_close;
      logic            do_term;
      parse_mode_type  m;
      logic [ROW_BITS-1:0] rc;
      logic [COL_BITS-1:0] fc;
      logic [COL_BITS-1:0] fc_final;
      rowchk_type      chk;
      rowchk_type      chk_n;

      is_end = item.end_of_data || (item.data_byte == CHAR_NUL);
      is_q   = (item.data_byte == CHAR_QUOTE);
      is_s   = !is_q && (item.data_byte == separator);
      is_nl  = !is_q && !is_s &&
               ((item.data_byte == CHAR_CR) || (item.data_byte == CHAR_LF));
      skip     = 1'b0;
      do_close = 1'b0;
      do_term  = 1'b0;
      m        = mode;
      rc       = row_cnt;
      fc       = field_cnt;
      fc_final = field_cnt;
      chk      = '{first: first_fields, seen: mm_seen, row: mm_row, fields: mm_fields};
      chk_n    = chk;

      mode_in         = mode;
      any_seen_in     = any_seen;
      row_cnt_in      = row_cnt;
      field_cnt_in    = field_cnt;
      first_fields_in = first_fields;
      mm_seen_in      = mm_seen;
      mm_row_in       = mm_row;
      mm_fields_in    = mm_fields;
      has_result      = 1'b0;
      result          = '0;
      result.expected_columns = col_out(first_fields);

      if (mode == MODE_DONE) begin
         if (is_end) begin
            mode_in         = MODE_START;
            any_seen_in     = 1'b0;
            row_cnt_in      = '0;
            field_cnt_in    = '0;
            first_fields_in = '0;
            mm_seen_in      = 1'b0;
            mm_row_in       = '0;
            mm_fields_in    = '0;
         end
      end else if (is_end) begin
         has_result      = 1'b1;
         result.finished = 1'b1;
         if (mode == MODE_QUOTED) begin
            result.status       = STATUS_UNCLOSED;
            result.row_index    = row_out(row_cnt);
            result.column_index = col_out(field_cnt);
         end else begin
            do_close = (mode == MODE_PLAIN) || (mode == MODE_QSEEN) ||
                       (((mode == MODE_START) || (mode == MODE_AFTER_CR)) && !any_seen);
            if (do_close) begin
               fc_final = col_inc(field_cnt);
            end
            if (do_close || field_cnt != '0) begin
               chk_n = close_row(chk, row_cnt, fc_final);
            end
            result.field_end        = do_close;
            result.row_end          = do_close || (field_cnt != '0);
            result.expected_columns = col_out(chk_n.first);
            if (chk_n.seen) begin
               result.status       = STATUS_MISMATCH;
               result.row_index    = row_out(chk_n.row);
               result.column_index = col_out(chk_n.fields);
            end else begin
               result.status       = STATUS_OK;
               result.row_index    = row_out(row_cnt);
               result.column_index = col_out(fc_final);
            end
         end
         // every end of data re-arms the parse
         mode_in         = MODE_START;
         any_seen_in     = 1'b0;
         row_cnt_in      = '0;
         field_cnt_in    = '0;
         first_fields_in = '0;
         mm_seen_in      = 1'b0;
         mm_row_in       = '0;
         mm_fields_in    = '0;
      end else begin
         if (m == MODE_AFTER_CR) begin
            m = MODE_START;
            skip = (item.data_byte == CHAR_LF);   // LF of a CRLF pair
         end
         mode_in = m;
         if (!skip) begin
            unique case (m)
               MODE_START: begin
                  if (any_seen && field_cnt == '0 && row_cnt != '1) begin
                     rc = row_cnt + 1'b1;
                  end
                  any_seen_in = 1'b1;
                  if (is_q) begin
                     mode_in = MODE_QUOTED;
                  end else if (is_s || is_nl) begin
                     do_term = 1'b1;
                  end else begin
                     mode_in           = MODE_PLAIN;
                     has_result        = 1'b1;
                     result.out_byte   = item.data_byte;
                     result.byte_valid = 1'b1;
                  end
               end
               MODE_PLAIN: begin
                  if (is_q) begin
                     mode_in         = MODE_DONE;
                     has_result      = 1'b1;
                     result.finished = 1'b1;
                     result.status   = STATUS_QUOTE_BARE;
                  end else if (is_s || is_nl) begin
                     do_term = 1'b1;
                  end else begin
                     has_result        = 1'b1;
                     result.out_byte   = item.data_byte;
                     result.byte_valid = 1'b1;
                  end
               end
               MODE_QUOTED: begin
                  if (is_q) begin
                     mode_in = MODE_QSEEN;
                  end else begin
                     has_result        = 1'b1;
                     result.out_byte   = item.data_byte;
                     result.byte_valid = 1'b1;
                  end
               end
               MODE_QSEEN: begin
                  if (is_q) begin
                     mode_in           = MODE_QUOTED;
                     has_result        = 1'b1;
                     result.out_byte   = CHAR_QUOTE;
                     result.byte_valid = 1'b1;
                  end else if (is_s || is_nl) begin
                     do_term = 1'b1;
                  end else begin
                     mode_in         = MODE_DONE;
                     has_result      = 1'b1;
                     result.finished = 1'b1;
                     result.status   = STATUS_AFTER_QUOT;
                  end
               end
               default: begin
                  mode_in = m;
               end
            endcase
         end

         if (do_term) begin
            has_result          = 1'b1;
            result.field_end    = 1'b1;
            result.column_index = col_out(fc);
            fc_final            = col_inc(fc);
            if (is_s) begin
               mode_in = MODE_START;
               fc      = fc_final;
            end else begin
               chk_n   = close_row(chk, rc, fc_final);
               result.row_end          = 1'b1;
               result.expected_columns = col_out(chk_n.first);
               fc      = '0;
               mode_in = (item.data_byte == CHAR_CR) ? MODE_AFTER_CR : MODE_START;
            end
         end

         result.row_index = row_out(rc);
         if (result.byte_valid) begin
            result.column_index = col_out(fc);
         end
         if (result.finished) begin
            result.column_index = col_out(fc);
         end
         row_cnt_in      = rc;
         field_cnt_in    = fc;
         first_fields_in = chk_n.first;
         mm_seen_in      = chk_n.seen;
         mm_row_in       = chk_n.row;
         mm_fields_in    = chk_n.fields;
      end
   end

endmodule

/* hw/rtl/csvt_rsp_fifo.sv */
// csvt_rsp_fifo: small register FIFO that holds result beats.
// Its level lets the input side stall ahead of time; uses csvt_pkg.
module csvt_rsp_fifo
   import csvt_pkg::*;
#(
   parameter int unsigned DEPTH = 3
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  rsp_payload_type              push_data,
   input  logic                         pop,
   output logic                         out_valid,
   output rsp_payload_type              out_data,
   output logic [$clog2(DEPTH+1)-1:0]   level
);

   localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_BITS = $clog2(DEPTH+1);
   localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(DEPTH - 1);

   rsp_payload_type       entry_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  do_pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign level     = count_ff;
   assign do_pop    = pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
